// ----- hdl/otsu_pkg.sv -----
package otsu_pkg;

  localparam int BINS    = 256;
  localparam int BIN_W   = $clog2(BINS);
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int SUM_W   = CNT_W + BIN_W;
  localparam int D_W     = SUM_W + CNT_W;
  localparam int D2_W    = 2 * D_W;
  localparam int DEN_W   = 2 * CNT_W;
  localparam int MA_W    = D2_W;
  localparam int MB_W    = D_W;
  localparam int DIG_W   = 8;
  localparam int DIGITS  = (MB_W + DIG_W - 1) / DIG_W;
  localparam int MBP_W   = DIGITS * DIG_W;
  localparam int K_W     = $clog2(DIGITS);
  localparam int P_W     = MA_W + MBP_W;
  localparam int QDEPTH  = 4;
  localparam int QA_W    = $clog2(QDEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;
  } in_t;

  typedef struct packed {
    logic [BIN_W-1:0] threshold;
    logic             overflow;
  } out_t;

  typedef struct packed {
    logic [BIN_W-1:0] level;
    logic             last;
  } q_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [P_W-1:0] p;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    S_BUILD,
    S_RD,
    S_ACC,
    S_MUL,
    S_CMP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_X,
    OP_Y,
    OP_D2,
    OP_DEN,
    OP_LHS,
    OP_RHS
  } op_t;

endpackage

// ----- hdl/otsu_threshold_unit.sv -----
// otsu threshold unit
// in channel: one pixel request per cycle (in_valid/in_ready, in_data),
//   last_pixel marks the final pixel of a frame
// out channel: one request per frame (out_valid/out_ready, out_data) with the
//   threshold and the count overflow flag
// pixels stream into a 256-bin histogram at one per cycle through a 4-entry
//   queue and a read-modify-write pipeline on the histogram ram
// after the last pixel the sweep runs over the grey levels; each level with a
//   nonempty background and foreground uses the shared 8-bit-digit multiplier six
//   times, a level with an empty background skips it, and the sweep ends once the
//   foreground is empty or the top level is done
// input is not taken during the sweep; the queue fills and in_ready drops
// the result waits in an output register; a stalled receiver holds the next
//   frame's result, while pixel intake resumes as soon as a result is loaded
// reset clears the histogram valid bits, the count and the overflow flag at
//   once; no clearing pass is needed, and the same happens after each frame
module otsu_threshold_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  otsu_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output otsu_pkg::out_t  out_data
);
  import otsu_pkg::*;

  logic     q_valid, q_pop;
  q_t       q_head;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  otsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  otsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  otsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/otsu_front.sv -----
module otsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  otsu_pkg::in_t   in_data,
  output logic            q_valid,
  output otsu_pkg::q_t    q_head,
  input  logic            q_pop
);
  import otsu_pkg::*;

  q_t              q_r [QDEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QA_W:0]   cnt_r;
  logic            push, pop;
  q_t              entry;

  assign in_ready = (cnt_r != (QA_W+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // clamp out-of-range levels into the top bin
  always_comb begin
    entry.last = in_data.last_pixel;
    if (32'(in_data.pixel) > BINS - 1) begin
      entry.level = BIN_W'(BINS - 1);
    end else begin
      entry.level = BIN_W'(in_data.pixel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= entry;
    end
  end

endmodule

// ----- hdl/otsu_mul.sv -----
module otsu_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  otsu_pkg::mul_req_t  req,
  output otsu_pkg::mul_rsp_t  rsp
);
  import otsu_pkg::*;

  logic [MA_W-1:0]  a_r;
  logic [MBP_W-1:0] b_r;
  logic [P_W-1:0]   acc_r;
  logic [K_W-1:0]   k_r;
  logic             busy_r, done_r;
  logic [MA_W+DIG_W-1:0] part;

  // one digit of b per cycle while busy, most significant first
  assign part = a_r * b_r[MBP_W-1 -: DIG_W];

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == K_W'(DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= MBP_W'(req.b);
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << DIG_W) + P_W'(part);
      b_r   <= b_r << DIG_W;
    end
  end

endmodule

// ----- hdl/otsu_back.sv -----
module otsu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  otsu_pkg::q_t        q_head,
  output logic                q_pop,
  output otsu_pkg::mul_req_t  mul_req,
  input  otsu_pkg::mul_rsp_t  mul_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output otsu_pkg::out_t      out_data
);
  import otsu_pkg::*;

  logic [CNT_W-1:0] mem [BINS];
  logic [BINS-1:0]  vld_r;
  logic [CNT_W-1:0] rdata_r;
  logic             rvld_r;
  logic [BIN_W-1:0] rd_addr;

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [CNT_W-1:0] total_r;
  logic [SUM_W-1:0] sum_r;
  logic             ovf_r;

  logic             s2_wr_r, s2_last_r;
  logic [BIN_W-1:0] s2_addr_r;
  logic             fwd_v_r;
  logic [BIN_W-1:0] fwd_addr_r;
  logic [CNT_W-1:0] fwd_val_r;
  logic [CNT_W-1:0] cnt_old, cnt_new;

  logic [BIN_W-1:0] t_r, best_t_r;
  logic [CNT_W-1:0] wb_r, wf_r, h, wb_n;
  logic [SUM_W-1:0] sumb_r;
  logic [D_W-1:0]   x_r, d_r, y;
  logic [D2_W-1:0]  d2_r, best_num_r;
  logic [DEN_W-1:0] den_r, best_den_r;
  logic [P_W-1:0]   lhs_r, rhs_r;
  logic             mul_wait_r;

  logic             out_valid_r;
  out_t             out_data_r;
  logic             load_out;

  assign q_pop   = (state_r == S_BUILD) && !s2_last_r && q_valid;
  assign rd_addr = (state_r == S_BUILD) ? q_head.level : t_r;
  assign h       = rvld_r ? rdata_r : '0;
  assign wb_n    = wb_r + h;
  assign y       = mul_rsp.p[D_W-1:0];

  assign cnt_old = (fwd_v_r && fwd_addr_r == s2_addr_r) ? fwd_val_r
                 : (rvld_r ? rdata_r : '0);
  assign cnt_new = cnt_old + 1'b1;

  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    mul_req.start = (state_r == S_MUL) && !mul_wait_r;
    unique case (op_r)
      OP_X: begin
        mul_req.a = MA_W'(sumb_r);
        mul_req.b = MB_W'(total_r);
      end
      OP_Y: begin
        mul_req.a = MA_W'(sum_r);
        mul_req.b = MB_W'(wb_r);
      end
      OP_D2: begin
        mul_req.a = MA_W'(d_r);
        mul_req.b = d_r;
      end
      OP_DEN: begin
        mul_req.a = MA_W'(wb_r);
        mul_req.b = MB_W'(wf_r);
      end
      OP_LHS: begin
        mul_req.a = d2_r;
        mul_req.b = MB_W'(best_den_r);
      end
      OP_RHS: begin
        mul_req.a = best_num_r;
        mul_req.b = MB_W'(den_r);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_BUILD: begin
        if (s2_last_r) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (wb_n == '0) begin
          state_nxt = (t_r == BIN_W'(BINS - 1)) ? S_DONE : S_RD;
        end else if (total_r == wb_n) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_rsp.done && op_r == OP_RHS) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = (t_r == BIN_W'(BINS - 1)) ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_BUILD;
        end
      end
      default: state_nxt = S_BUILD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BUILD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // histogram store
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (s2_wr_r) begin
      mem[s2_addr_r] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      rvld_r      <= 1'b0;
      total_r     <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      s2_wr_r     <= 1'b0;
      s2_last_r   <= 1'b0;
      fwd_v_r     <= 1'b0;
      mul_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_X;
    end else begin
      rvld_r <= vld_r[rd_addr];
      if (q_pop) begin
        s2_last_r <= q_head.last;
        if (total_r == CNT_MAX) begin
          ovf_r   <= 1'b1;
          s2_wr_r <= 1'b0;
        end else begin
          total_r <= total_r + 1'b1;
          sum_r   <= sum_r + SUM_W'(q_head.level);
          s2_wr_r <= 1'b1;
        end
      end else begin
        s2_wr_r   <= 1'b0;
        s2_last_r <= 1'b0;
      end
      if (s2_wr_r) begin
        vld_r[s2_addr_r] <= 1'b1;
        fwd_v_r          <= 1'b1;
      end
      if (mul_req.start) begin
        mul_wait_r <= 1'b1;
      end else if (mul_rsp.done) begin
        mul_wait_r <= 1'b0;
      end
      if (state_r == S_ACC) begin
        op_r <= OP_X;
      end else if (state_r == S_MUL && mul_rsp.done) begin
        unique case (op_r)
          OP_X:    op_r <= OP_Y;
          OP_Y:    op_r <= OP_D2;
          OP_D2:   op_r <= OP_DEN;
          OP_DEN:  op_r <= OP_LHS;
          OP_LHS:  op_r <= OP_RHS;
          OP_RHS:  op_r <= OP_X;
          default: op_r <= OP_X;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        vld_r       <= '0;
        fwd_v_r     <= 1'b0;
        total_r     <= '0;
        sum_r       <= '0;
        ovf_r       <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_addr_r <= q_head.level;
    end
    if (s2_wr_r) begin
      fwd_addr_r <= s2_addr_r;
      fwd_val_r  <= cnt_new;
    end
    if (load_out) begin
      out_data_r.threshold <= best_t_r;
      out_data_r.overflow  <= ovf_r;
    end
    unique case (state_r)
      S_BUILD: begin
        t_r        <= '0;
        wb_r       <= '0;
        sumb_r     <= '0;
        best_num_r <= '0;
        best_den_r <= DEN_W'(1);
        best_t_r   <= '0;
      end
      S_ACC: begin
        wb_r <= wb_n;
        if (wb_n == '0) begin
          t_r <= t_r + 1'b1;
        end else begin
          sumb_r <= sumb_r + SUM_W'(t_r) * SUM_W'(h);
          wf_r   <= total_r - wb_n;
        end
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          unique case (op_r)
            OP_X:    x_r   <= mul_rsp.p[D_W-1:0];
            OP_Y:    d_r   <= (x_r >= y) ? x_r - y : y - x_r;
            OP_D2:   d2_r  <= mul_rsp.p[D2_W-1:0];
            OP_DEN:  den_r <= mul_rsp.p[DEN_W-1:0];
            OP_LHS:  lhs_r <= mul_rsp.p;
            OP_RHS:  rhs_r <= mul_rsp.p;
            default: x_r   <= x_r;
          endcase
        end
      end
      S_CMP: begin
        t_r <= t_r + 1'b1;
        if (lhs_r > rhs_r) begin
          best_num_r <= d2_r;
          best_den_r <= den_r;
          best_t_r   <= t_r;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_req.start && mul_rsp.busy))
    else $error("multiplier started while busy");

  a_pop_build: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_BUILD && !s2_last_r))
    else $error("pixel popped outside histogram build");

  a_wb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_CMP) |-> (wb_r < total_r))
    else $error("background weight out of range");
`endif

endmodule

// ----- test/otsu_threshold_unit_tb.sv -----
module otsu_threshold_unit_tb;
  import otsu_pkg::*;

  class threshold_board;
    longint unsigned hist [BINS];
    longint unsigned total;
    bit              ovf;
    out_t            pending_q [$];
    int              errors;
    int              matched;

    function new();
      clear();
      errors  = 0;
      matched = 0;
    endfunction

    function void clear();
      foreach (hist[i]) hist[i] = 0;
      total = 0;
      ovf   = 1'b0;
    endfunction

    function logic [BIN_W-1:0] best_level();
      logic [255:0]    x, y, d, d2, lhs, rhs, best_num, best_den, den;
      longint unsigned sum, sum_b, w_b, w_f;
      logic [BIN_W-1:0] best_t;
      sum      = 0;
      sum_b    = 0;
      w_b      = 0;
      best_num = '0;
      best_den = 256'd1;
      best_t   = '0;
      for (int t = 0; t < BINS; t++) sum += t * hist[t];
      for (int t = 0; t < BINS; t++) begin
        w_b += hist[t];
        if (w_b == 0) continue;
        w_f = total - w_b;
        if (w_f == 0) break;
        sum_b += t * hist[t];
        x   = 256'(sum_b) * 256'(total);
        y   = 256'(sum) * 256'(w_b);
        d   = (x >= y) ? x - y : y - x;
        d2  = d * d;
        den = 256'(w_b) * 256'(w_f);
        lhs = d2 * best_den;
        rhs = best_num * den;
        if (lhs > rhs) begin
          best_num = d2;
          best_den = den;
          best_t   = t[BIN_W-1:0];
        end
      end
      return best_t;
    endfunction

    function void note_pixel(in_t req);
      out_t res;
      if (total >= longint'(CNT_MAX)) begin
        ovf = 1'b1;
      end else begin
        hist[req.pixel]++;
        total++;
      end
      if (req.last_pixel) begin
        res.threshold = best_level();
        res.overflow  = ovf;
        pending_q.push_back(res);
        clear();
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result thr=%0d ovf=%0b",
                                   got.threshold, got.overflow);
        return;
      end
      want = pending_q.pop_front();
      if (got.threshold !== want.threshold || got.overflow !== want.overflow) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected thr=%0d ovf=%0b, got thr=%0d ovf=%0b",
                   want.threshold, want.overflow, got.threshold, got.overflow);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  threshold_board board;
  bit quiet;
  bit long_hold;
  int pixels_sent;
  int frames_sent;

  otsu_threshold_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 100_000_000);
    $display("timeout");
    $display("** otsu_threshold_unit: FAILED **");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last, input bit may_idle);
    in_t req;
    req.pixel      = pix;
    req.last_pixel = last;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(req);
    pixels_sent++;
    if (last) frames_sent++;
    if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int len, input int lo, input int hi);
    for (int i = 0; i < len; i++)
      send_pixel(PIX_W'($urandom_range(hi, lo)), i == len - 1, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  // receiver
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_result(out_data);
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int lo, hi, len, a;
    board       = new();
    quiet       = 1'b0;
    long_hold   = 1'b0;
    pixels_sent = 0;
    frames_sent = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    send_pixel(8'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    send_pixel(8'd77, 1'b0, 1'b0);
    send_pixel(8'd77, 1'b0, 1'b0);
    send_pixel(8'd77, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    // symmetric levels give equal variances
    send_pixel(8'd10, 1'b0, 1'b0);
    send_pixel(8'd20, 1'b0, 1'b0);
    send_pixel(8'd30, 1'b1, 1'b0);
    send_pixel(8'd1, 1'b0, 1'b0);
    send_pixel(8'd2, 1'b0, 1'b0);
    send_pixel(8'd253, 1'b0, 1'b0);
    send_pixel(8'd254, 1'b1, 1'b0);
    drain();
    send_frame(3, 0, 255);

    // stalled receiver while frames keep coming
    long_hold = 1'b1;
    for (int f = 0; f < 8; f++) send_frame($urandom_range(1, 6), 100, 110);
    drain();

    while (pixels_sent < 1450) begin
      if (pixels_sent > 1200) quiet = 1'b1;
      a = $urandom_range(0, 9);
      if (a < 6) begin
        lo = $urandom_range(0, 250);
        hi = lo + $urandom_range(0, 5);
        len = $urandom_range(1, 25);
      end else if (a < 9) begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, 255);
        len = $urandom_range(1, 40);
      end else begin
        lo = 0;
        hi = 255;
        len = $urandom_range(2, 120);
      end
      send_frame(len, lo, hi);
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);

    $display("%0d pixels in %0d frames, %0d thresholds matched",
             pixels_sent, frames_sent, board.matched);
    $display("directed, tie, long receiver stall and random frames exercised");
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("** otsu_threshold_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.pending_q.size());
      $display("** otsu_threshold_unit: FAILED **");
    end
    $finish;
  end

endmodule
